/* hdl/bfm_pkg.sv */
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types and constants of the 3x3 box filter: register map,
// configuration widths and reset values, coordinate width.
// ----------------------------------------------------------------------------
`default_nettype none

package bfm_pkg;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 11;
   localparam int COORD_BITS     = 10;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;
   typedef logic [COORD_BITS-1:0]     coord_type;

   localparam csr_index_type CSR_FRAME_WIDTH  = 1'b0;
   localparam csr_index_type CSR_FRAME_HEIGHT = 1'b1;

   localparam csr_data_type FRAME_WIDTH_RESET  = 11'd320;
   localparam csr_data_type FRAME_HEIGHT_RESET = 11'd200;

   localparam csr_data_type FRAME_MIN    = 11'd3;
   localparam csr_data_type HEIGHT_LIMIT = 11'd1024;

endpackage

`default_nettype wire

/* hdl/bfm_line_mem.sv */
// ----------------------------------------------------------------------------
// bfm_line_mem
// Line store memory: one entry per column holding {upper, middle} pixels.
// Registered read, one write per cycle, write-to-read forwarding for a
// read issued in the same cycle as a write to the same column.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_line_mem #(
   parameter int DEPTH = 1024,
   parameter int DATA_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [DATA_BITS-1:0]       wr_data,
   output logic      [DATA_BITS-1:0]       rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;
   logic [DATA_BITS-1:0] fwd_data_ff;
   logic                 fwd_ff;
   logic                 fwd_in;

   assign fwd_in = rd_en ? (wr_en && (wr_addr == rd_addr)) : fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_data_ff;

endmodule

`default_nettype wire

/* hdl/bfm_window_sum.sv */
// ----------------------------------------------------------------------------
// bfm_window_sum
// 3x3 window shift register and registered sum of its nine pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_window_sum #(
   parameter int PIXEL_BITS = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    shift_en,
   input  wire logic                    sum_en,
   input  wire logic [PIXEL_BITS-1:0]   col_upper,
   input  wire logic [PIXEL_BITS-1:0]   col_middle,
   input  wire logic [PIXEL_BITS-1:0]   col_lower,
   output logic      [PIXEL_BITS+3:0]   sum
);

   localparam int SUM_BITS = PIXEL_BITS + 4;

   logic [PIXEL_BITS-1:0] win_ff [3][3];
   logic [SUM_BITS-1:0]   sum_ff;
   logic [SUM_BITS-1:0]   sum_in;

   always_comb begin
      sum_in = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            sum_in = sum_in + SUM_BITS'(win_ff[r][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (shift_en) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= col_upper;
         win_ff[1][2] <= col_middle;
         win_ff[2][2] <= col_lower;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

/* hdl/box_filter_3x3_mean_unit.sv */
// ----------------------------------------------------------------------------
// box_filter_3x3_mean_unit
// Streaming 3x3 mean filter over a raster pixel stream with line store
// memory, window register and divide-by-nine output stage.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall req_pixel, req_frame_start
//   rsp      out  rsp_valid/rsp_stall rsp_mean, rsp_out_col, rsp_out_row,
//                                     rsp_frame_done
//   csr      in   csr_wr_en           csr_index, csr_wr_data
//
// One pixel per cycle sustained while no result is blocked. The rate is
// set by the line store memory: each cycle it reads the current column and
// writes the previous pixel's column, forwarding when both hit one column.
// Reset clears counters, window and pipeline valids; the line store memory
// is not cleared. rsp_stall freezes the whole pipeline while a result waits;
// req_stall is high exactly then.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_3x3_mean_unit
   import bfm_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [PIXEL_BITS-1:0]   req_pixel,
   input  wire logic                    req_frame_start,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic      [PIXEL_BITS-1:0]   rsp_mean,
   output coord_type                    rsp_out_col,
   output coord_type                    rsp_out_row,
   output logic                         rsp_frame_done,
   input  wire logic                    csr_wr_en,
   input  wire csr_index_type           csr_index,
   input  wire csr_data_type            csr_wr_data
);

   localparam int CW       = $clog2(MAX_WIDTH);
   localparam int MWB      = $clog2(MAX_WIDTH + 1);
   localparam int WB       = (MWB > CSR_DATA_BITS) ? MWB : CSR_DATA_BITS;
   localparam int OW       = (CW > COORD_BITS) ? CW : COORD_BITS;
   localparam int SUM_BITS = PIXEL_BITS + 4;
   localparam int DIV_SH   = SUM_BITS + 4;
   localparam logic [SUM_BITS:0] DIV_M = (SUM_BITS + 1)'(((64'd1 << DIV_SH) + 64'd8) / 64'd9);

   // configuration
   csr_data_type frame_width_ff;
   csr_data_type frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   logic [WB-1:0]  fw_ext;
   logic [CW-1:0]  w_last;
   coord_type      h_last;

   always_comb begin
      fw_ext = WB'(frame_width_ff);
      if (frame_width_ff < FRAME_MIN) begin
         w_last = CW'(2);
      end else if (fw_ext > WB'(MAX_WIDTH)) begin
         w_last = CW'(MAX_WIDTH - 1);
      end else begin
         w_last = CW'(fw_ext - WB'(1));
      end
      if (frame_height_ff < FRAME_MIN) begin
         h_last = COORD_BITS'(2);
      end else if (frame_height_ff > HEIGHT_LIMIT) begin
         h_last = COORD_BITS'(HEIGHT_LIMIT - 11'd1);
      end else begin
         h_last = COORD_BITS'(frame_height_ff - 11'd1);
      end
   end

   // handshake
   logic adv;
   logic accept;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   // position counters
   logic [CW-1:0]  col_ff, col_in, col_cur;
   coord_type      row_ff, row_in, row_cur;
   logic [OW-1:0]  col_m1;
   logic           col_wrap;

   always_comb begin
      col_cur  = req_frame_start ? '0 : col_ff;
      row_cur  = req_frame_start ? '0 : row_ff;
      col_wrap = (col_cur >= w_last);
      col_m1   = OW'(col_cur) - OW'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = (row_cur >= h_last) ? '0 : row_cur + COORD_BITS'(1);
         end else begin
            col_in = col_cur + CW'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line store read data arrives
   logic                  v1_ff, e1_ff, d1_ff;
   logic [PIXEL_BITS-1:0] px1_ff;
   logic [CW-1:0]         addr1_ff;
   coord_type             oc1_ff, or1_ff;
   logic [2*PIXEL_BITS-1:0] rd_data, wr_data;
   logic [PIXEL_BITS-1:0] up_rd, mid_rd;

   always_ff @(posedge clock) begin
      if (accept) begin
         px1_ff   <= req_pixel;
         addr1_ff <= col_cur;
         oc1_ff   <= col_m1[COORD_BITS-1:0];
         or1_ff   <= row_cur - COORD_BITS'(1);
         e1_ff    <= (col_cur >= CW'(2)) && (row_cur >= COORD_BITS'(2));
         d1_ff    <= col_wrap && (row_cur >= h_last);
      end
   end

   assign up_rd   = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
   assign mid_rd  = rd_data[PIXEL_BITS-1:0];
   assign wr_data = {mid_rd, px1_ff};

   bfm_line_mem #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (2 * PIXEL_BITS)
   ) u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .wr_en   (adv && v1_ff),
      .wr_addr (addr1_ff),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // stage 2: window holds the neighborhood; stage 3: sum registered
   logic              e2_ff, d2_ff, e3_ff, d3_ff;
   coord_type         oc2_ff, or2_ff, oc3_ff, or3_ff;
   logic [SUM_BITS-1:0] sum;

   bfm_window_sum #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (adv && v1_ff),
      .sum_en     (adv),
      .col_upper  (up_rd),
      .col_middle (mid_rd),
      .col_lower  (px1_ff),
      .sum        (sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         e2_ff        <= 1'b0;
         e3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= accept;
         e2_ff        <= v1_ff && e1_ff;
         e3_ff        <= e2_ff;
         rsp_valid_ff <= e3_ff;
      end
   end

   // divide by nine: exact reciprocal multiply over the sum range
   logic [2*SUM_BITS:0] prod;
   logic [2*SUM_BITS:0] quot;

   assign prod = (2*SUM_BITS+1)'(sum) * (2*SUM_BITS+1)'(DIV_M);
   assign quot = prod >> DIV_SH;

   logic [PIXEL_BITS-1:0] mean_ff;
   coord_type             oc_ff, or_ff;
   logic                  done_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         oc2_ff  <= oc1_ff;
         or2_ff  <= or1_ff;
         d2_ff   <= d1_ff;
         oc3_ff  <= oc2_ff;
         or3_ff  <= or2_ff;
         d3_ff   <= d2_ff;
         mean_ff <= quot[PIXEL_BITS-1:0];
         oc_ff   <= oc3_ff;
         or_ff   <= or3_ff;
         done_ff <= d3_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean       = mean_ff;
   assign rsp_out_col    = oc_ff;
   assign rsp_out_row    = or_ff;
   assign rsp_frame_done = done_ff;

endmodule

`default_nettype wire

/* hdl/bfm_checker.sv */
// ----------------------------------------------------------------------------
// bfm_checker
// Port-level checks of the box filter: result beat hold under stall,
// input stall origin, interior coordinates of results.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_checker
   import bfm_pkg::*;
#(
   parameter int PIXEL_BITS = 8
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [PIXEL_BITS-1:0] rsp_mean,
   input wire coord_type             rsp_out_col,
   input wire coord_type             rsp_out_row,
   input wire logic                  rsp_frame_done
);

   // a waiting result beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped under stall");

   // a waiting result beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_mean) && $stable(rsp_out_col)
         && $stable(rsp_out_row) && $stable(rsp_frame_done))
      else $error("rsp payload changed under stall");

   // input is held off only by a blocked result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without blocked rsp");

   // results never lie in the first row or the first column
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_col != '0) && (rsp_out_row != '0))
      else $error("result on a border position");

endmodule

bind box_filter_3x3_mean_unit bfm_checker #(
   .PIXEL_BITS (PIXEL_BITS)
) u_bfm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_mean       (rsp_mean),
   .rsp_out_col    (rsp_out_col),
   .rsp_out_row    (rsp_out_row),
   .rsp_frame_done (rsp_frame_done)
);

`default_nettype wire
